// ===== rtl/line_follow_pd_drive_assert.svh =====
// assertion macros used by the line follower top level
`ifndef LINE_FOLLOW_PD_DRIVE_ASSERT_SVH
`define LINE_FOLLOW_PD_DRIVE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LFPD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("line follower check failed");

// next-cycle implication, checked outside reset
`define LFPD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("line follower check failed");

`endif

// ===== rtl/lfpd_pkg.sv =====
package lfpd_pkg;

	// full motor duty and the slowdown applied on a cross line
	localparam int SPEED_MAX      = 255;
	localparam int CROSS_SLOWDOWN = 25;
	localparam int CROSS_SPEED    = (SPEED_MAX > CROSS_SLOWDOWN) ?
		(SPEED_MAX - CROSS_SLOWDOWN) : 0;

	// register indexes on the configuration port
	localparam logic [2:0] REG_SET_POINT       = 3'd0;
	localparam logic [2:0] REG_LOST_THRESHOLD  = 3'd1;
	localparam logic [2:0] REG_CROSS_THRESHOLD = 3'd2;
	localparam logic [2:0] REG_PROP_GAIN       = 3'd3;
	localparam logic [2:0] REG_DERIV_GAIN      = 3'd4;

	// register reset values
	localparam logic [9:0] RST_SET_POINT       = 10'd0;
	localparam logic [9:0] RST_LOST_THRESHOLD  = 10'd51;
	localparam logic [9:0] RST_CROSS_THRESHOLD = 10'd972;
	localparam logic [7:0] RST_PROP_GAIN       = 8'd24;
	localparam logic [7:0] RST_DERIV_GAIN      = 8'd80;

	typedef enum logic [1:0] {
		MODE_LOST  = 2'd0,
		MODE_CROSS = 2'd1,
		MODE_TRACK = 2'd2
	} mode_t;

	typedef struct packed {
		logic [9:0] set_point;
		logic [9:0] lost_threshold;
		logic [9:0] cross_threshold;
		logic [7:0] prop_gain;
		logic [7:0] deriv_gain;
	} cfg_t;

	typedef struct packed {
		logic [7:0] left_speed;
		logic [7:0] right_speed;
		mode_t      mode;
	} res_t;

endpackage

// ===== rtl/line_follow_pd_drive.sv =====
// a sample is held in the input register, then its result is captured in the result register
// throughput: one sample per cycle while the output does not stall, the input register refills while a result is taken
// stalls only when both the input register and the result register are full and out_ready is low
// reset: registers return to their defaults, last error to zero, both stages empty
`include "line_follow_pd_drive_assert.svh"

module line_follow_pd_drive (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [2:0] cfg_index,
	input  logic [9:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [9:0] sensor_sample,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] left_speed,
	output logic [7:0] right_speed,
	output logic [1:0] drive_mode
);

	lfpd_pkg::cfg_t     cfg;
	lfpd_pkg::res_t     res;
	logic signed [10:0] error;
	logic signed [10:0] last_error_q;
	logic               valid_s1;
	logic [9:0]         sample_s1;
	logic               out_valid_q;
	lfpd_pkg::res_t     res_q;
	logic               out_load;
	logic               track_load;

	lfpd_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lfpd_calc u_calc (
		.sample     (sample_s1),
		.cfg        (cfg),
		.last_error (last_error_q),
		.res        (res),
		.error      (error)
	);

	// stage handshake
	assign out_load   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready   = !valid_s1 || out_load;
	assign track_load = out_load && (res.mode == lfpd_pkg::MODE_TRACK);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (out_load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1 <= sensor_sample;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_q <= res;
		end
	end

	// error history, only tracking samples update it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_error_q <= 11'sd0;
		end else if (track_load) begin
			last_error_q <= error;
		end
	end

	assign out_valid   = out_valid_q;
	assign left_speed  = res_q.left_speed;
	assign right_speed = res_q.right_speed;
	assign drive_mode  = res_q.mode;

	// checks
	`LFPD_ASSERT_NOW(a_lost_stops, out_valid_q && (res_q.mode == lfpd_pkg::MODE_LOST), (res_q.left_speed == 8'd0) && (res_q.right_speed == 8'd0))
	`LFPD_ASSERT_NOW(a_track_one_full, out_valid_q && (res_q.mode == lfpd_pkg::MODE_TRACK), (res_q.left_speed == 8'(lfpd_pkg::SPEED_MAX)) || (res_q.right_speed == 8'(lfpd_pkg::SPEED_MAX)))
	`LFPD_ASSERT_NOW(a_stall_only_full, !in_ready, valid_s1 && out_valid_q && !out_ready)
	`LFPD_ASSERT_NEXT(a_last_error_hold, !track_load, $stable(last_error_q))

endmodule

// ===== rtl/lfpd_regs.sv =====
module lfpd_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [2:0]          cfg_index,
	input  logic [9:0]          cfg_data,
	output lfpd_pkg::cfg_t      cfg
);

	lfpd_pkg::cfg_t cfg_q;

	// register file, writes beyond the last index are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.set_point       <= lfpd_pkg::RST_SET_POINT;
			cfg_q.lost_threshold  <= lfpd_pkg::RST_LOST_THRESHOLD;
			cfg_q.cross_threshold <= lfpd_pkg::RST_CROSS_THRESHOLD;
			cfg_q.prop_gain       <= lfpd_pkg::RST_PROP_GAIN;
			cfg_q.deriv_gain      <= lfpd_pkg::RST_DERIV_GAIN;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				lfpd_pkg::REG_SET_POINT:       cfg_q.set_point       <= cfg_data;
				lfpd_pkg::REG_LOST_THRESHOLD:  cfg_q.lost_threshold  <= cfg_data;
				lfpd_pkg::REG_CROSS_THRESHOLD: cfg_q.cross_threshold <= cfg_data;
				lfpd_pkg::REG_PROP_GAIN:       cfg_q.prop_gain       <= cfg_data[7:0];
				lfpd_pkg::REG_DERIV_GAIN:      cfg_q.deriv_gain      <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/lfpd_calc.sv =====
module lfpd_calc (
	input  logic                 [9:0]  sample,
	input  lfpd_pkg::cfg_t              cfg,
	input  logic signed          [10:0] last_error,
	output lfpd_pkg::res_t              res,
	output logic signed          [10:0] error
);

	logic signed [11:0] deriv;
	logic signed [8:0]  kp_s;
	logic signed [8:0]  kd_s;
	logic signed [19:0] p_term;
	logic signed [20:0] d_term;
	logic signed [21:0] pd_sum;
	logic signed [21:0] pd_adj;
	logic signed [17:0] pd_div;
	logic signed [8:0]  pd;
	logic signed [9:0]  left_w;
	logic signed [9:0]  right_w;

	// error and its change since the last tracking sample
	assign error = $signed({1'b0, sample}) - $signed({1'b0, cfg.set_point});
	assign deriv = {error[10], error} - {last_error[10], last_error};

	// pd sum in signed q18.4, from gains in unsigned q4.4
	assign kp_s   = {1'b0, cfg.prop_gain};
	assign kd_s   = {1'b0, cfg.deriv_gain};
	assign p_term = 20'(kp_s) * 20'(error);
	assign d_term = 21'(kd_s) * 21'(deriv);
	assign pd_sum = {{2{p_term[19]}}, p_term} + {d_term[20], d_term};

	// drop the fraction, rounding toward zero
	assign pd_adj = pd_sum + (pd_sum[21] ? 22'sd15 : 22'sd0);
	assign pd_div = pd_adj[21:4];

	// saturate to the motor range
	always_comb begin
		if (pd_div > 18'(lfpd_pkg::SPEED_MAX)) begin
			pd = 9'(lfpd_pkg::SPEED_MAX);
		end else if (pd_div < -18'(lfpd_pkg::SPEED_MAX)) begin
			pd = -9'(lfpd_pkg::SPEED_MAX);
		end else begin
			pd = pd_div[8:0];
		end
	end

	// slow the motor on the side the line drifted to
	assign left_w  = 10'(lfpd_pkg::SPEED_MAX) + {pd[8], pd};
	assign right_w = 10'(lfpd_pkg::SPEED_MAX) - {pd[8], pd};

	// mode select, lost has priority over cross
	always_comb begin
		if (sample < cfg.lost_threshold) begin
			res.left_speed  = 8'd0;
			res.right_speed = 8'd0;
			res.mode        = lfpd_pkg::MODE_LOST;
		end else if (sample > cfg.cross_threshold) begin
			res.left_speed  = 8'(lfpd_pkg::CROSS_SPEED);
			res.right_speed = 8'(lfpd_pkg::CROSS_SPEED);
			res.mode        = lfpd_pkg::MODE_CROSS;
		end else if (pd[8]) begin
			res.left_speed  = left_w[7:0];
			res.right_speed = 8'(lfpd_pkg::SPEED_MAX);
			res.mode        = lfpd_pkg::MODE_TRACK;
		end else begin
			res.left_speed  = 8'(lfpd_pkg::SPEED_MAX);
			res.right_speed = right_w[7:0];
			res.mode        = lfpd_pkg::MODE_TRACK;
		end
	end

endmodule
